>>> src/sce_pkg.sv
// shared types and constants for the clause energy walker
package sce_pkg;

    // operation codes carried by an input word
    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_FLIP  = 2'd2
    } t_op;

    // configuration register indexes
    localparam logic [1:0] CFG_NUM_VARS    = 2'd0;
    localparam logic [1:0] CFG_NUM_CLAUSES = 2'd1;
    localparam logic [1:0] CFG_LOW_LIMIT   = 2'd2;

    // configuration reset values
    localparam logic [6:0] RST_NUM_VARS    = 7'd40;
    localparam logic [8:0] RST_NUM_CLAUSES = 9'd160;
    localparam logic [8:0] RST_LOW_LIMIT   = 9'd8;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;       // write one clause entry
        logic begin_eval; // take assignment or flip, clear the walk
        logic walk;       // step through the clause table
        logic div_go;     // launch the histogram division
        logic finish;     // update start and peak, register the result
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic walk_done;
        logic div_done;
    } t_dp_stat;

endpackage

>>> src/sce_ctrl.sv
// controller state machine sequencing walk, division and result
module sce_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [1:0]        i_operation,
    input  sce_pkg::t_dp_stat i_stat,
    output sce_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIV
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   w_accept;

    assign w_accept = i_start && !r_busy;
    assign o_busy   = r_busy;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_operation == sce_pkg::OP_LOAD) begin
                    o_cmd.load = 1'b1;
                end
                if (w_accept && (i_operation == sce_pkg::OP_START ||
                                 i_operation == sce_pkg::OP_FLIP)) begin
                    o_cmd.begin_eval = 1'b1;
                    n_state          = ST_WALK;
                end
            end
            ST_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_stat.walk_done) begin
                    o_cmd.div_go = 1'b1;
                    n_state      = ST_DIV;
                end
            end
            ST_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and busy flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
        end
    end

endmodule

>>> src/sce_divider.sv
// restoring divider, one quotient bit per cycle
module sce_divider #(
    parameter int unsigned DW = 19,
    parameter int unsigned VW = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    localparam int unsigned CW = $clog2(DW + 1);

    logic [CW-1:0] r_cnt;
    logic          r_done;
    logic [DW-1:0] r_dvd;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [VW:0]   w_rem_sh;
    logic          w_fit;
    logic [VW:0]   w_diff;

    // one shift and trial subtract
    assign w_rem_sh = {r_rem, r_dvd[DW-1]};
    assign w_fit    = (w_rem_sh >= {1'b0, r_dvs});
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_dvd <= {r_dvd[DW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[VW-1:0] : w_rem_sh[VW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;

endmodule

>>> src/sce_datapath.sv
// datapath: config registers, clause table, energy walk and result words
module sce_datapath #(
    parameter int unsigned MAX_VARIABLES      = 64,
    parameter int unsigned MAX_CLAUSE_ENTRIES = 256,
    parameter int unsigned BIN_COUNT          = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sce_pkg::t_dp_cmd  i_cmd,
    output sce_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_clause_index,
    input  logic signed [7:0] i_literal_a,
    input  logic signed [7:0] i_literal_b,
    input  logic signed [7:0] i_literal_c,
    input  logic [63:0]       i_assignment,
    input  logic [5:0]        i_flip_index,
    output logic              o_done,
    output logic [8:0]        o_energy,
    output logic [8:0]        o_barrier,
    output logic              o_low_energy,
    output logic [5:0]        o_hist_bin
);

    localparam int unsigned CNT_W = $clog2(MAX_CLAUSE_ENTRIES + 1);
    localparam int unsigned EW    = (CNT_W > 9) ? CNT_W : 9;
    localparam int unsigned AW    = $clog2(MAX_CLAUSE_ENTRIES);
    localparam int unsigned BW    = $clog2(BIN_COUNT + 1);
    localparam int unsigned DW    = EW + BW;
    localparam int unsigned VW    = EW + 1;

    // literal true under the assignment, false when out of range
    function automatic logic lit_true(input logic [7:0] lit, input logic [6:0] nv,
                                      input logic [63:0] asg);
        logic [7:0] mag;
        logic [5:0] idx;
        logic       in_range;
        mag      = lit[7] ? (8'd0 - lit) : lit;
        idx      = 6'(mag - 8'd1);
        in_range = (mag != 8'd0) && (mag <= {1'b0, nv});
        return in_range && (asg[idx] ^ lit[7]);
    endfunction

    logic [6:0]    r_num_vars;
    logic [8:0]    r_num_clauses;
    logic [8:0]    r_low_limit;
    logic [23:0]   r_mem [MAX_CLAUSE_ENTRIES];
    logic [23:0]   r_rdata;
    logic [63:0]   r_assign;
    logic          r_is_start;
    logic [EW-1:0] r_addr;
    logic          r_rd_vld;
    logic [EW-1:0] r_energy;
    logic [EW-1:0] r_start_e;
    logic [EW-1:0] r_peak_e;
    logic          r_done;
    logic [8:0]    r_energy_o;
    logic [8:0]    r_barrier_o;
    logic          r_low_o;
    logic [5:0]    r_bin_o;

    logic [6:0]    w_nv;
    logic [EW-1:0] w_nc_ext;
    logic [EW-1:0] w_n_eff;
    logic [EW-1:0] w_idx_ext;
    logic          w_rd_en;
    logic          w_unsat;
    logic [DW-1:0] w_product;
    logic          w_div_done;
    logic [DW-1:0] w_quot;
    logic [DW-1:0] w_bin;
    logic [EW-1:0] n_peak;
    logic [EW-1:0] n_start;
    logic [EW-1:0] w_barrier;

    // effective counts
    assign w_nv      = (r_num_vars > 7'(MAX_VARIABLES)) ? 7'(MAX_VARIABLES) : r_num_vars;
    assign w_nc_ext  = EW'(r_num_clauses);
    assign w_n_eff   = (w_nc_ext > EW'(MAX_CLAUSE_ENTRIES)) ?
                       EW'(MAX_CLAUSE_ENTRIES) : w_nc_ext;
    assign w_idx_ext = EW'(i_clause_index);
    assign w_rd_en   = i_cmd.walk && (r_addr < w_n_eff);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_vars    <= sce_pkg::RST_NUM_VARS;
            r_num_clauses <= sce_pkg::RST_NUM_CLAUSES;
            r_low_limit   <= sce_pkg::RST_LOW_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sce_pkg::CFG_NUM_VARS:    r_num_vars    <= i_cfg_data[6:0];
                sce_pkg::CFG_NUM_CLAUSES: r_num_clauses <= i_cfg_data;
                sce_pkg::CFG_LOW_LIMIT:   r_low_limit   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clause table, write on load, registered read during the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (w_idx_ext < EW'(MAX_CLAUSE_ENTRIES))) begin
            r_mem[w_idx_ext[AW-1:0]] <= {i_literal_c, i_literal_b, i_literal_a};
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_addr[AW-1:0]];
        end
    end

    // clause with no true literal
    assign w_unsat = !lit_true(r_rdata[7:0],   w_nv, r_assign) &&
                     !lit_true(r_rdata[15:8],  w_nv, r_assign) &&
                     !lit_true(r_rdata[23:16], w_nv, r_assign);

    // assignment register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_assign <= '0;
        end else if (i_cmd.begin_eval) begin
            if (i_operation == sce_pkg::OP_START) begin
                r_assign <= i_assignment;
            end else begin
                r_assign[i_flip_index] <= ~r_assign[i_flip_index];
            end
        end
    end

    // walk address, read pipe and energy count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_energy   <= '0;
            r_is_start <= 1'b0;
        end else if (i_cmd.begin_eval) begin
            r_addr     <= '0;
            r_rd_vld   <= 1'b0;
            r_energy   <= '0;
            r_is_start <= (i_operation == sce_pkg::OP_START);
        end else begin
            r_rd_vld <= w_rd_en;
            if (w_rd_en) begin
                r_addr <= r_addr + EW'(1);
            end
            if (r_rd_vld && w_unsat) begin
                r_energy <= r_energy + EW'(1);
            end
        end
    end

    assign o_stat.walk_done = i_cmd.walk && (r_addr >= w_n_eff) && !r_rd_vld;
    assign o_stat.div_done  = w_div_done;

    // energy times bin count over clauses plus one
    assign w_product = DW'(r_energy) * DW'(BIN_COUNT);

    sce_divider #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (w_product),
        .i_divisor  (VW'(w_n_eff) + VW'(1)),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_bin = (w_quot >= DW'(BIN_COUNT)) ? DW'(BIN_COUNT - 1) : w_quot;

    // start and peak update, saturating barrier
    assign n_start   = r_is_start ? r_energy : r_start_e;
    assign n_peak    = r_is_start ? r_energy :
                       ((r_energy > r_peak_e) ? r_energy : r_peak_e);
    assign w_barrier = (n_peak >= n_start) ? (n_peak - n_start) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_e <= '0;
            r_peak_e  <= '0;
            r_done    <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_start_e <= n_start;
                r_peak_e  <= n_peak;
            end
        end
    end

    // result word registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_energy_o  <= r_energy[8:0];
            r_barrier_o <= w_barrier[8:0];
            r_low_o     <= (r_energy <= EW'(r_low_limit));
            r_bin_o     <= w_bin[5:0];
        end
    end

    assign o_done       = r_done;
    assign o_energy     = r_energy_o;
    assign o_barrier    = r_barrier_o;
    assign o_low_energy = r_low_o;
    assign o_hist_bin   = r_bin_o;

endmodule

>>> src/sat_clause_energy_walker.sv
// top level of the clause energy walker
// a load word writes one table entry without raising busy and gives no result; a start or flip
// word holds busy while the walk reads the effective clause count of table entries at one entry
// per cycle, and then while the 15-bit serial bin division runs
// one word in flight at a time; o_done pulses as busy falls and cannot be held off
// synchronous active-low reset clears control, config and energies but not the clause table or the result words
module sat_clause_energy_walker #(
    parameter int unsigned MAX_VARIABLES      = 64,
    parameter int unsigned MAX_CLAUSE_ENTRIES = 256,
    parameter int unsigned BIN_COUNT          = 50
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [8:0]        i_cfg_data,
    input  logic [1:0]        i_operation,
    input  logic [7:0]        i_clause_index,
    input  logic signed [7:0] i_literal_a,
    input  logic signed [7:0] i_literal_b,
    input  logic signed [7:0] i_literal_c,
    input  logic [63:0]       i_assignment,
    input  logic [5:0]        i_flip_index,
    output logic              o_done,
    output logic [8:0]        o_energy,
    output logic [8:0]        o_barrier,
    output logic              o_low_energy,
    output logic [5:0]        o_hist_bin
);

    sce_pkg::t_dp_cmd  w_cmd;
    sce_pkg::t_dp_stat w_stat;

    // controller
    sce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_operation (i_operation),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_busy      (busy)
    );

    // datapath
    sce_datapath #(
        .MAX_VARIABLES      (MAX_VARIABLES),
        .MAX_CLAUSE_ENTRIES (MAX_CLAUSE_ENTRIES),
        .BIN_COUNT          (BIN_COUNT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_operation    (i_operation),
        .i_clause_index (i_clause_index),
        .i_literal_a    (i_literal_a),
        .i_literal_b    (i_literal_b),
        .i_literal_c    (i_literal_c),
        .i_assignment   (i_assignment),
        .i_flip_index   (i_flip_index),
        .o_done         (o_done),
        .o_energy       (o_energy),
        .o_barrier      (o_barrier),
        .o_low_energy   (o_low_energy),
        .o_hist_bin     (o_hist_bin)
    );

endmodule

>>> src/sce_checker.sv
// port-level checker for the clause energy walker, bound to the top level
module sce_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] i_operation,
    input logic       o_done,
    input logic [8:0] o_energy,
    input logic [5:0] o_hist_bin
);

    // start or flip word makes the block busy
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == sce_pkg::OP_START ||
                            i_operation == sce_pkg::OP_FLIP)) |=> busy)
        else $error("evaluation word did not raise busy");

    // load word completes at once with no result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_operation == sce_pkg::OP_LOAD) |=> (!busy && !o_done))
        else $error("load word raised busy or a result");

    // a result appears only once the block is idle again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result word while busy or without an evaluation");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // zero energy falls in the first bin
    a_zero_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_energy == 9'd0) |-> (o_hist_bin == 6'd0))
        else $error("zero energy outside the first bin");

endmodule

bind sat_clause_energy_walker sce_checker u_sce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_done      (o_done),
    .o_energy    (o_energy),
    .o_hist_bin  (o_hist_bin)
);
